// ===== design/spdw_pkg.sv =====
package spdw_pkg;

    // Panel geometry used by the mirror mapping.
    localparam int unsigned PANEL_WIDTH  = 240;
    localparam int unsigned PANEL_HEIGHT = 320;

    localparam logic [15:0] X_MIRROR_BASE = 16'(PANEL_WIDTH - 1);
    localparam logic [15:0] Y_MIRROR_BASE = 16'(PANEL_HEIGHT - 1);

    // Request kinds; any kind with bit 1 set is a reset-pin event.
    localparam logic [1:0] REQ_COMMAND = 2'd0;
    localparam logic [1:0] REQ_DATA    = 2'd1;

    // Command codes.
    localparam logic [7:0] CMD_SWRESET = 8'h01;
    localparam logic [7:0] CMD_CASET   = 8'h2A;
    localparam logic [7:0] CMD_PASET   = 8'h2B;
    localparam logic [7:0] CMD_RAMWR   = 8'h2C;
    localparam logic [7:0] CMD_MADCTL  = 8'h36;

    // Operand bookkeeping.
    localparam int unsigned OPERAND_DEPTH = 4;
    localparam logic [2:0]  OPERAND_FULL  = 3'd4;
    localparam logic [2:0]  PIXEL_BYTES   = 3'd2;

    // Bit positions inside the access control register.
    localparam int unsigned ACC_SWAP = 0;
    localparam int unsigned ACC_MX   = 1;
    localparam int unsigned ACC_MY   = 2;

    // Pixel job handed from the command decoder to the mapper.
    typedef struct packed {
        logic        emit;
        logic [15:0] color;
        logic [15:0] col;
        logic [15:0] row;
        logic [2:0]  access;
    } pixel_job_t;

    // Finished pixel as it leaves the block.
    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_t;

endpackage

// ===== design/spdw_req_if.sv =====
interface spdw_req_if;

    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] byte_value;

    modport source (output valid, output req_type, output byte_value, input ready);
    modport sink   (input valid, input req_type, input byte_value, output ready);

endinterface

// ===== design/spdw_pix_if.sv =====
interface spdw_pix_if;

    logic        valid;
    logic        ready;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    modport source (output valid, output pixel_x, output pixel_y, output red,
                    output green, output blue, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input red,
                    input green, input blue, output ready);

endinterface

// ===== design/spdw_ctrl.sv =====
module spdw_ctrl
    import spdw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [1:0] req_type,
    input  logic [7:0] byte_value,
    output pixel_job_t job
);

    logic [15:0] col_start_reg, col_start_next;
    logic [15:0] col_end_reg, col_end_next;
    logic [15:0] row_start_reg, row_start_next;
    logic [15:0] row_end_reg, row_end_next;
    logic [15:0] cursor_col_reg, cursor_col_next;
    logic [15:0] cursor_row_reg, cursor_row_next;
    logic [2:0]  access_reg, access_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  op_reg [OPERAND_DEPTH];
    logic [7:0]  op_next [OPERAND_DEPTH];

    logic [7:0]  op_wr [OPERAND_DEPTH];
    logic [2:0]  cnt_stored;
    logic [15:0] pair_lo;
    logic [15:0] pair_hi;
    logic        emit;

    // Store the data byte in the next free operand slot, if any is left.
    always_comb
    begin
        op_wr      = op_reg;
        cnt_stored = cnt_reg;
        if (cnt_reg < OPERAND_FULL)
        begin
            op_wr[cnt_reg[1:0]] = byte_value;
            cnt_stored          = 3'(cnt_reg + 3'd1);
        end
        pair_lo = {op_wr[0], op_wr[1]};
        pair_hi = {op_wr[2], op_wr[3]};
        emit    = (req_type == REQ_DATA) && (cmd_reg == CMD_RAMWR)
                  && (cnt_stored >= PIXEL_BYTES);
    end

    // Next state for one transfer.
    always_comb
    begin
        col_start_next  = col_start_reg;
        col_end_next    = col_end_reg;
        row_start_next  = row_start_reg;
        row_end_next    = row_end_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        access_next     = access_reg;
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        unique case (req_type)
            REQ_COMMAND:
            begin
                cmd_next = byte_value;
                cnt_next = 3'd0;
                if (byte_value == CMD_SWRESET)
                begin
                    access_next = 3'd0;
                end
                else if (byte_value == CMD_RAMWR)
                begin
                    cursor_col_next = col_start_reg;
                    cursor_row_next = row_start_reg;
                end
            end
            REQ_DATA:
            begin
                op_next  = op_wr;
                cnt_next = cnt_stored;
                unique case (cmd_reg)
                    CMD_CASET:
                    begin
                        if (cnt_stored >= OPERAND_FULL)
                        begin
                            col_start_next = pair_lo;
                            col_end_next   = pair_hi;
                        end
                    end
                    CMD_PASET:
                    begin
                        if (cnt_stored >= OPERAND_FULL)
                        begin
                            row_start_next = pair_lo;
                            row_end_next   = pair_hi;
                        end
                    end
                    CMD_RAMWR:
                    begin
                        if (emit)
                        begin
                            cnt_next = 3'd0;
                            // Advance within the window; the row is unbounded.
                            if (cursor_col_reg < col_end_reg)
                            begin
                                cursor_col_next = 16'(cursor_col_reg + 16'd1);
                            end
                            else
                            begin
                                cursor_col_next = col_start_reg;
                                cursor_row_next = 16'(cursor_row_reg + 16'd1);
                            end
                        end
                    end
                    CMD_MADCTL:
                    begin
                        access_next = op_wr[0][7:5];
                    end
                    default:
                    begin
                        cnt_next = 3'd0;
                    end
                endcase
            end
            default:
            begin
                // Reset pin event.
                access_next = 3'd0;
                cnt_next    = 3'd0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_start_reg  <= '0;
            col_end_reg    <= '0;
            row_start_reg  <= '0;
            row_end_reg    <= '0;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            access_reg     <= '0;
            cmd_reg        <= '0;
            cnt_reg        <= '0;
        end
        else if (fire)
        begin
            col_start_reg  <= col_start_next;
            col_end_reg    <= col_end_next;
            row_start_reg  <= row_start_next;
            row_end_reg    <= row_end_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            access_reg     <= access_next;
            cmd_reg        <= cmd_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Operand bytes carry no reset; the count says which are live.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            op_reg <= op_next;
        end
    end

    // The pixel uses the cursor as it stood before the advance.
    always_comb
    begin
        job.emit   = emit;
        job.color  = pair_lo;
        job.col    = cursor_col_reg;
        job.row    = cursor_row_reg;
        job.access = access_reg;
    end

endmodule

// ===== design/spdw_map.sv =====
module spdw_map
    import spdw_pkg::*;
(
    input  pixel_job_t job,
    output pixel_t     pix
);

    logic [15:0] x_swap;
    logic [15:0] y_swap;

    // Expand RGB565 by replicating the top bits of each channel.
    // Swap first, then the row mirror, then the column mirror when MX is clear.
    always_comb
    begin
        pix.red   = {job.color[15:11], job.color[15:13]};
        pix.green = {job.color[10:5], job.color[10:9]};
        pix.blue  = {job.color[4:0], job.color[4:2]};
        if (job.access[ACC_SWAP])
        begin
            x_swap = job.row;
            y_swap = job.col;
        end
        else
        begin
            x_swap = job.col;
            y_swap = job.row;
        end
        pix.pixel_y = job.access[ACC_MY] ? 16'(Y_MIRROR_BASE - y_swap) : y_swap;
        pix.pixel_x = job.access[ACC_MX] ? x_swap : 16'(X_MIRROR_BASE - x_swap);
    end

endmodule

// ===== design/spi_display_pixel_writer.sv =====
// Pixel writer behind the SPI command interface of a TFT panel controller.
//
// Channel req carries one bus byte per transfer: req_type 0 is a command
// byte, 1 a data byte, 2 or 3 a reset-pin event; byte_value is the byte.
// Channel pix carries one written pixel per transfer: its mapped panel
// coordinate and 8-bit red, green and blue. A pixel comes out on every
// second data byte after a memory write command; other bytes give nothing.
//
// Each byte is first captured in an input register and decoded there
// against the command state; a pixel is written to the output register
// as its byte is decoded. A byte can be taken in every cycle unless a
// pixel waits at a full output register; the command and cursor registers
// update on every accepted byte, which sets that rate of one byte per cycle.
//
// Reset clears the address window, cursor, access control, current command
// and byte count. When the receiver holds pix.ready low, the output
// register keeps its pixel; bytes that make no pixel still flow, and req
// stalls only once a byte that makes a pixel finds the output register full.
module spi_display_pixel_writer
    import spdw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    spdw_req_if.sink   req,
    spdw_pix_if.source pix
);

    logic       in_valid_reg, in_valid_next;
    logic [1:0] in_type_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    pixel_t     out_data_reg;

    pixel_job_t job;
    pixel_t     mapped;
    logic       out_free;
    logic       advance;
    logic       fire;
    logic       in_ready;

    spdw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .req_type   (in_type_reg),
        .byte_value (in_byte_reg),
        .job        (job)
    );

    spdw_map u_map (
        .job (job),
        .pix (mapped)
    );

    // Flow control between the input and output registers.
    assign out_free  = !out_valid_reg || pix.ready;
    assign advance   = !job.emit || out_free;
    assign fire      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign req.ready = in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = req.valid;
        end
        out_valid_next = out_valid_reg;
        if (fire && job.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && in_ready)
        begin
            in_type_reg <= req.req_type;
            in_byte_reg <= req.byte_value;
        end
        if (fire && job.emit)
        begin
            out_data_reg <= mapped;
        end
    end

    assign pix.valid   = out_valid_reg;
    assign pix.pixel_x = out_data_reg.pixel_x;
    assign pix.pixel_y = out_data_reg.pixel_y;
    assign pix.red     = out_data_reg.red;
    assign pix.green   = out_data_reg.green;
    assign pix.blue    = out_data_reg.blue;

    // A byte that makes no pixel never blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !job.emit) |-> in_ready)
        else $error("input stalled on a byte that makes no pixel");

    // The input stalls only when a pixel meets a full, stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && job.emit && pix.valid && !pix.ready))
        else $error("input stalled without a blocked pixel");

    // A decoded pixel shows up at the output on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && job.emit) |=> pix.valid)
        else $error("decoded pixel did not reach the output register");

endmodule

// ===== tb/spi_display_pixel_writer_tb.sv =====
module spi_display_pixel_writer_tb;
    import spdw_pkg::*;

    // Reset-pin events: any request kind with bit 1 set.
    localparam logic [1:0] REQ_PIN_RESET    = 2'd2;
    localparam logic [1:0] REQ_PIN_RESET_HI = 2'd3;

    // Cycles to wait after the last pixel before the bus is considered quiet.
    localparam int HOLD_OFF    = 4;
    localparam int MAX_PRINTED = 50;
    localparam int RANDOM_BYTES = 440;

    logic clk;
    logic rst_n;

    spdw_req_if req_bus();
    spdw_pix_if pix_bus();

    spi_display_pixel_writer u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .pix   (pix_bus)
    );

    // Controller state as the testbench expects it.
    logic [15:0] win_col_lo = '0;
    logic [15:0] win_col_hi = '0;
    logic [15:0] win_row_lo = '0;
    logic [15:0] win_row_hi = '0;
    logic [15:0] cur_col    = '0;
    logic [15:0] cur_row    = '0;
    logic [2:0]  acc_bits   = '0;
    logic [7:0]  cur_cmd    = '0;
    logic [7:0]  opnd [4]   = '{default: '0};
    logic [2:0]  opnd_cnt   = '0;

    // Pixels still owed by the block, oldest first.
    pixel_t pending_pixels[$];

    int  err_count      = 0;
    int  pixels_checked = 0;
    int  bytes_sent     = 0;
    int  cmd_sent       = 0;
    int  data_sent      = 0;
    int  pin_resets     = 0;
    int  noise_sent     = 0;
    bit  full_rate      = 1'b0;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Apply one accepted bus byte to the expected state; a completed pixel
    // is queued.
    function automatic void predict_byte(input logic [1:0] kind, input logic [7:0] val);
        logic [15:0] color;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] t;
        pixel_t      px;
        if (kind[1])
        begin
            acc_bits = '0;
            opnd_cnt = '0;
        end
        else if (kind == REQ_COMMAND)
        begin
            cur_cmd  = val;
            opnd_cnt = '0;
            if (val == CMD_SWRESET)
                acc_bits = '0;
            else if (val == CMD_RAMWR)
            begin
                cur_col = win_col_lo;
                cur_row = win_row_lo;
            end
        end
        else
        begin
            if (opnd_cnt < OPERAND_FULL)
            begin
                opnd[opnd_cnt[1:0]] = val;
                opnd_cnt = opnd_cnt + 3'd1;
            end
            case (cur_cmd)
                CMD_CASET:
                begin
                    if (opnd_cnt >= OPERAND_FULL)
                    begin
                        win_col_lo = {opnd[0], opnd[1]};
                        win_col_hi = {opnd[2], opnd[3]};
                    end
                end
                CMD_PASET:
                begin
                    if (opnd_cnt >= OPERAND_FULL)
                    begin
                        win_row_lo = {opnd[0], opnd[1]};
                        win_row_hi = {opnd[2], opnd[3]};
                    end
                end
                CMD_RAMWR:
                begin
                    if (opnd_cnt >= PIXEL_BYTES)
                    begin
                        // RGB565 expanded by replicating the top bits.
                        color    = {opnd[0], opnd[1]};
                        px.red   = {color[15:11], color[15:13]};
                        px.green = {color[10:5], color[10:9]};
                        px.blue  = {color[4:0], color[4:2]};
                        x = cur_col;
                        y = cur_row;
                        if (acc_bits[ACC_SWAP])
                        begin
                            t = x;
                            x = y;
                            y = t;
                        end
                        if (acc_bits[ACC_MY])
                            y = Y_MIRROR_BASE - y;
                        if (!acc_bits[ACC_MX])
                            x = X_MIRROR_BASE - x;
                        px.pixel_x = x;
                        px.pixel_y = y;
                        pending_pixels.push_back(px);
                        // Step the cursor through the window; rows are unbounded.
                        if (cur_col < win_col_hi)
                            cur_col = cur_col + 16'd1;
                        else
                        begin
                            cur_col = win_col_lo;
                            cur_row = cur_row + 16'd1;
                        end
                        opnd_cnt = '0;
                    end
                end
                CMD_MADCTL:
                begin
                    acc_bits = opnd[0][7:5];
                end
                default:
                begin
                    opnd_cnt = '0;
                end
            endcase
        end
    endfunction

    // Sender idle time: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (full_rate)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 6);
    endfunction

    // Window coordinates: mostly small, some at the top of the 16-bit range.
    function automatic logic [15:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'($urandom);
        if (r < 18)
            return 16'hFFFF - 16'($urandom_range(3));
        return 16'($urandom_range(300));
    endfunction

    // Drive one bus byte and hold it until the transfer happens.
    // Called and returns at a falling edge; valid stays high on return.
    task automatic send_byte(input logic [1:0] kind, input logic [7:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_bus.valid      <= 1'b0;
            req_bus.req_type   <= 2'($urandom);
            req_bus.byte_value <= 8'($urandom);
            repeat (gap) @(negedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= kind;
        req_bus.byte_value <= val;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predict_byte(kind, val);
        bytes_sent++;
        if (kind[1])
            pin_resets++;
        else if (kind == REQ_COMMAND)
            cmd_sent++;
        else
            data_sent++;
        @(negedge clk);
    endtask

    task automatic send_cmd(input logic [7:0] code);
        send_byte(REQ_COMMAND, code);
    endtask

    task automatic send_data(input logic [7:0] val);
        send_byte(REQ_DATA, val);
    endtask

    task automatic send_pixel(input logic [15:0] color);
        send_data(color[15:8]);
        send_data(color[7:0]);
    endtask

    task automatic send_pin_reset();
        send_byte($urandom_range(1) ? REQ_PIN_RESET : REQ_PIN_RESET_HI, 8'($urandom));
    endtask

    // Address set command with a chosen number of data bytes; past four
    // the bytes are random filler.
    task automatic send_window(input logic [7:0] code, input logic [15:0] lo,
                               input logic [15:0] hi, input int count);
        logic [7:0] bytes [4];
        bytes = '{lo[15:8], lo[7:0], hi[15:8], hi[7:0]};
        send_cmd(code);
        for (int i = 0; i < count; i++)
            send_data(i < 4 ? bytes[i] : 8'($urandom));
    endtask

    // Stop sending and let every owed pixel come out.
    task automatic wait_for_pixels();
        req_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
        @(negedge clk);
    endtask

    // Data and reset-pin bytes before any command do nothing.
    task automatic test_idle_bus_bytes();
        send_data(8'hA5);
        send_byte(REQ_PIN_RESET, 8'h00);
    endtask

    // Window at the top of the 16-bit range, with end below start and an
    // extra address byte.
    task automatic test_window_extremes();
        send_window(CMD_CASET, 16'hFFFF, 16'hFFFE, 5);
        send_window(CMD_PASET, 16'h0000, 16'hFFFF, 4);
        send_cmd(CMD_RAMWR);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
    endtask

    // All access bits set, extra access byte, software reset, and a
    // reset-pin event that drops half a pixel.
    task automatic test_access_and_resets();
        send_cmd(CMD_MADCTL);
        send_data(8'hE0);
        send_data(8'h1F);
        send_cmd(CMD_RAMWR);
        send_pixel(16'hF81F);
        send_cmd(CMD_SWRESET);
        send_data(8'h33);
        send_cmd(CMD_RAMWR);
        send_data(8'h07);
        send_byte(REQ_PIN_RESET_HI, 8'hFF);
        send_pixel(16'h07E0);
    endtask

    // Back-to-back pixels with the receiver always ready.
    task automatic test_full_rate();
        full_rate = 1'b1;
        send_window(CMD_CASET, 16'd0, 16'd3, 4);
        send_cmd(CMD_RAMWR);
        for (int i = 0; i < 24; i++)
            send_pixel(16'($urandom));
        full_rate = 1'b0;
    endtask

    // Mostly well-formed command sequences with random content, plus
    // broken sequences, resets and stray commands.
    task automatic test_random_traffic(input int target);
        int   base;
        int   r;
        int   count;
        int   before_noise;
        bit   drained_mid;
        logic [15:0] lo;
        base = bytes_sent;
        drained_mid = 1'b0;
        while (bytes_sent - noise_sent - base < target)
        begin
            // Once, let the block run dry in the middle of the traffic.
            if (!drained_mid && (bytes_sent - base) > target / 2)
            begin
                wait_for_pixels();
                drained_mid = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 30)
            begin
                lo = pick_coord();
                r = $urandom_range(99);
                count = (r < 80) ? 4 : (r < 90) ? $urandom_range(3) : $urandom_range(6, 5);
                send_window($urandom_range(1) ? CMD_CASET : CMD_PASET, lo,
                            ($urandom_range(99) < 10) ? 16'($urandom)
                                                      : lo + 16'($urandom_range(6)),
                            count);
            end
            else if (r < 45)
            begin
                send_cmd(CMD_MADCTL);
                count = ($urandom_range(99) < 80) ? 1 : $urandom_range(3, 2);
                for (int i = 0; i < count; i++)
                    send_data(8'($urandom));
            end
            else if (r < 85)
            begin
                send_cmd(CMD_RAMWR);
                count = $urandom_range(12, 1);
                for (int i = 0; i < count; i++)
                begin
                    if ($urandom_range(99) < 4)
                        send_pin_reset();
                    send_pixel(16'($urandom));
                end
                if ($urandom_range(99) < 15)
                    send_data(8'($urandom));
            end
            else if (r < 90)
                send_pin_reset();
            else if (r < 94)
                send_cmd(CMD_SWRESET);
            else
            begin
                // Stray command and data; these do not count toward the target.
                before_noise = bytes_sent;
                send_cmd(8'($urandom));
                count = $urandom_range(3);
                for (int i = 0; i < count; i++)
                    send_data(8'($urandom));
                noise_sent += bytes_sent - before_noise;
            end
        end
    endtask

    // Receiver: ready in runs, stalls mostly short and sometimes long.
    initial
    begin
        int   span;
        logic level;
        pix_bus.ready = 1'b0;
        span  = 0;
        level = 1'b0;
        forever
        begin
            @(negedge clk);
            if (full_rate)
                pix_bus.ready <= 1'b1;
            else
            begin
                if (span == 0)
                begin
                    r_pick : begin
                        int r;
                        r = $urandom_range(99);
                        if (r < 55)
                        begin
                            level = 1'b1;
                            span  = $urandom_range(20, 1);
                        end
                        else if (r < 90)
                        begin
                            level = 1'b0;
                            span  = $urandom_range(3, 1);
                        end
                        else
                        begin
                            level = 1'b0;
                            span  = $urandom_range(40, 8);
                        end
                    end
                end
                pix_bus.ready <= level;
                span--;
            end
        end
    end

    // Compare each pixel transfer with the oldest owed pixel.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pix_bus.valid && pix_bus.ready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("pixel at (%0d,%0d) with none owed",
                                          pix_bus.pixel_x, pix_bus.pixel_y));
            else
            begin
                want = pending_pixels.pop_front();
                if (pix_bus.pixel_x !== want.pixel_x)
                    report_mismatch($sformatf("pixel %0d x %h, want %h",
                                              pixels_checked, pix_bus.pixel_x, want.pixel_x));
                if (pix_bus.pixel_y !== want.pixel_y)
                    report_mismatch($sformatf("pixel %0d y %h, want %h",
                                              pixels_checked, pix_bus.pixel_y, want.pixel_y));
                if (pix_bus.red !== want.red)
                    report_mismatch($sformatf("pixel %0d red %h, want %h",
                                              pixels_checked, pix_bus.red, want.red));
                if (pix_bus.green !== want.green)
                    report_mismatch($sformatf("pixel %0d green %h, want %h",
                                              pixels_checked, pix_bus.green, want.green));
                if (pix_bus.blue !== want.blue)
                    report_mismatch($sformatf("pixel %0d blue %h, want %h",
                                              pixels_checked, pix_bus.blue, want.blue));
                pixels_checked++;
            end
        end
    end

    // Reset, then the tests in turn.
    initial
    begin
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = REQ_COMMAND;
        req_bus.byte_value = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_bus_bytes();
        test_window_extremes();
        wait_for_pixels();
        test_access_and_resets();
        wait_for_pixels();
        test_full_rate();
        wait_for_pixels();
        test_random_traffic(RANDOM_BYTES);
        wait_for_pixels();

        $display("Sent %0d bus bytes: %0d commands, %0d data bytes, %0d reset-pin events.",
                 bytes_sent, cmd_sent, data_sent, pin_resets);
        $display("Checked %0d pixels over random windows, access modes and stalls; %0d errors.",
                 pixels_checked, err_count);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/spdw_pkg.sv
design/spdw_req_if.sv
design/spdw_pix_if.sv
design/spdw_ctrl.sv
design/spdw_map.sv
design/spi_display_pixel_writer.sv
tb/spi_display_pixel_writer_tb.sv
